>>> hdl/sha_pkg.sv
// Package for the SHA-256 stream hasher: payload structs, round constants,
// initial vector, controller/datapath command and status types. No dependencies.
package sha_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam int         LEN_START = 56;

  // Source selection for a byte written into the message schedule window.
  localparam logic [1:0] SRC_DATA = 2'd0;
  localparam logic [1:0] SRC_PAD  = 2'd1;
  localparam logic [1:0] SRC_ZERO = 2'd2;
  localparam logic [1:0] SRC_LEN  = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       wr_byte;    // write one byte at fill position
    logic [1:0] byte_src;
    logic       add_len;    // bump bit length by eight
    logic       start;      // load working vars, clear round count
    logic       round;      // run one compression round
    logic       finish;     // add working vars into chain
    logic       reload;     // load initial vector and clear counters
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [5:0] fill;
    logic       last_round;
  } dp_stat_t;

  localparam logic [31:0] INIT_VEC [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

>>> hdl/sha_datapath.sv
// Datapath of the SHA-256 stream hasher: 16-word schedule window that doubles
// as the block buffer, working variables, chain words, counters. Uses sha_pkg.
module sha_datapath
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     cmd,
  input  logic [7:0]  data_byte,
  input  logic [2:0]  rd_index,
  output dp_stat_t    stat,
  output logic [31:0] rd_word
);

  logic [31:0] w [16];
  logic [31:0] v [8];
  logic [31:0] chain [8];
  logic [5:0]  fill;
  logic [63:0] bit_len;
  logic [5:0]  rnd;
  logic [7:0]  wr_val;
  logic [31:0] s0, s1, w_new, t1, t2, ch, maj, e1, a0;

  // Byte chosen for the buffer write; length bytes are taken big-endian.
  always_comb begin
    unique case (cmd.byte_src)
      SRC_DATA: wr_val = data_byte;
      SRC_PAD:  wr_val = PAD_BYTE;
      SRC_ZERO: wr_val = 8'h00;
      SRC_LEN:  wr_val = bit_len[8 * (7 - {29'd0, fill[2:0]}) +: 8];
      default:  wr_val = 8'h00;
    endcase
  end

  // Schedule expansion and one round of compression.
  always_comb begin
    s0 = {w[1][6:0], w[1][31:7]} ^ {w[1][17:0], w[1][31:18]} ^ (w[1] >> 3);
    s1 = {w[14][16:0], w[14][31:17]} ^ {w[14][18:0], w[14][31:19]} ^ (w[14] >> 10);
    w_new = s0 + w[0] + s1 + w[9];
    e1 = {v[4][5:0], v[4][31:6]} ^ {v[4][10:0], v[4][31:11]} ^ {v[4][24:0], v[4][31:25]};
    ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
    t1 = v[7] + e1 + ch + ROUND_K[rnd] + w[0];
    a0 = {v[0][1:0], v[0][31:2]} ^ {v[0][12:0], v[0][31:13]} ^ {v[0][21:0], v[0][31:22]};
    maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t2 = a0 + maj;
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_byte) begin
      w[fill[5:2]][8 * (3 - {30'd0, fill[1:0]}) +: 8] <= wr_val;
    end
    if (cmd.start) begin
      for (int i = 0; i < 8; i++) v[i] <= chain[i];
    end
    if (cmd.round) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i + 1];
      w[15] <= w_new;
      v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
      v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
    end
  end

  // Control counters and chain words.
  always_ff @(posedge clk) begin
    if (rst || cmd.reload) begin
      fill    <= '0;
      bit_len <= '0;
      rnd     <= '0;
      for (int i = 0; i < 8; i++) chain[i] <= INIT_VEC[i];
    end else begin
      if (cmd.wr_byte) fill <= fill + 6'd1;
      if (cmd.add_len) bit_len <= bit_len + 64'd8;
      if (cmd.start) rnd <= '0;
      if (cmd.round) rnd <= rnd + 6'd1;
      if (cmd.finish) begin
        for (int i = 0; i < 8; i++) chain[i] <= chain[i] + v[i];
      end
    end
  end

  assign stat.fill       = fill;
  assign stat.last_round = (rnd == 6'd63);
  assign rd_word         = chain[rd_index];

endmodule

>>> hdl/sha_ctrl.sv
// Controller of the SHA-256 stream hasher: sequences byte writes, padding,
// compression rounds and digest output. Uses sha_pkg.
module sha_ctrl
  import sha_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  in_item_t  in_item,
  output logic      in_stall,
  input  dp_stat_t  stat,
  output dp_cmd_t   cmd,
  output logic      out_valid,
  input  logic      out_stall,
  output logic [2:0] out_index
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PAD  = 3'd1;
  localparam logic [2:0] ST_FILL = 3'd2;
  localparam logic [2:0] ST_RUN  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0] state, state_next;
  logic       ending, ending_next;   // message end pending
  logic       padded, padded_next;   // 0x80 already written
  logic       len_zone, len_zone_next; // length field goes in this block
  logic [2:0] idx, idx_next;
  logic       take;
  // Set when the block just compressed carried the length field.
  logic       lenblk, lenblk_next;

  assign in_stall  = (state != ST_IDLE);
  assign take      = in_valid && !in_stall;
  assign out_valid = (state == ST_OUT);
  assign out_index = idx;

  always_comb begin
    state_next    = state;
    ending_next   = ending;
    padded_next   = padded;
    len_zone_next = len_zone;
    idx_next      = idx;
    cmd           = '0;
    unique case (state)
      ST_IDLE: begin
        if (take) begin
          ending_next = in_item.end_of_message;
          padded_next = 1'b0;
          if (in_item.has_byte) begin
            cmd.wr_byte  = 1'b1;
            cmd.byte_src = SRC_DATA;
            cmd.add_len  = 1'b1;
            if (stat.fill == 6'd63) begin
              cmd.start  = 1'b1;
              state_next = ST_RUN;
            end else if (in_item.end_of_message) begin
              state_next = ST_PAD;
            end
          end else if (in_item.end_of_message) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        // Marker byte, then zeros up to the length field or block end.
        cmd.wr_byte   = 1'b1;
        cmd.byte_src  = SRC_PAD;
        padded_next   = 1'b1;
        len_zone_next = (stat.fill < 6'(LEN_START));
        state_next    = ST_FILL;
        if (stat.fill == 6'd63) begin
          cmd.start  = 1'b1;
          state_next = ST_RUN;
        end
      end
      ST_FILL: begin
        cmd.wr_byte = 1'b1;
        if (stat.fill >= 6'(LEN_START) && len_zone) begin
          cmd.byte_src = SRC_LEN;
        end else begin
          cmd.byte_src = SRC_ZERO;
        end
        if (stat.fill == 6'd63) begin
          cmd.start  = 1'b1;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.round = 1'b1;
        if (stat.last_round) state_next = ST_FIN;
      end
      ST_FIN: begin
        cmd.finish = 1'b1;
        idx_next   = '0;
        if (!ending) begin
          state_next = ST_IDLE;
        end else if (!padded) begin
          state_next = ST_PAD;
        end else if (lenblk) begin
          state_next = ST_OUT;
        end else begin
          // Marker spilled past the length field: a zero block with length follows.
          len_zone_next = 1'b1;
          state_next    = ST_FILL;
        end
      end
      ST_OUT: begin
        if (!out_stall) begin
          idx_next = idx + 3'd1;
          if (idx == 3'd7) begin
            cmd.reload = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    lenblk_next = lenblk;
    if (cmd.start) lenblk_next = (state == ST_FILL) && len_zone;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      ending   <= 1'b0;
      padded   <= 1'b0;
      len_zone <= 1'b0;
      idx      <= '0;
      lenblk   <= 1'b0;
    end else begin
      state    <= state_next;
      ending   <= ending_next;
      padded   <= padded_next;
      len_zone <= len_zone_next;
      idx      <= idx_next;
      lenblk   <= lenblk_next;
    end
  end

endmodule

>>> hdl/sha256_stream_hasher.sv
// SHA-256 stream hasher, top level. Joins sha_ctrl and sha_datapath.
// Depends on sha_pkg.
//
// Usage: the input channel takes one word per item: a message byte
// (when has_byte is set) and an end_of_message flag. A byte that does
// not fill the 64-byte block is taken without a stall. The 64th byte
// starts a compression of 64 rounds, one per cycle, done by the round
// unit in the datapath; the input stays stalled through the rounds and
// the addition into the chain. An end_of_message word pads the message
// and runs one or two compressions, then sends eight digest words,
// word_index 0 to 7, last_word on the eighth. The input stays stalled
// until the last digest word is taken. A stall on the output holds the
// current digest word in place. After the eighth word the chain reloads
// the initial vector for the next message. Reset (synchronous, active
// high) loads the initial vector and clears the fill count and the bit
// length.
module sha256_stream_hasher
  import sha_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  in_item_t  in_data,
  output logic      in_stall,
  output logic      out_valid,
  output out_item_t out_data,
  input  logic      out_stall
);

  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic [2:0]  idx;
  logic [31:0] word;

  sha_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_item(in_data),
    .in_stall(in_stall), .stat(stat), .cmd(cmd), .out_valid(out_valid),
    .out_stall(out_stall), .out_index(idx)
  );

  sha_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .data_byte(in_data.data_byte),
    .rd_index(idx), .stat(stat), .rd_word(word)
  );

  assign out_data.digest_word = word;
  assign out_data.word_index  = idx;
  assign out_data.last_word   = (idx == 3'd7);

endmodule

>>> hdl/sha_checker.sv
// Port checker for the SHA-256 stream hasher, bound to the top level.
// Depends on sha_pkg.
module sha_checker
  import sha_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_stall,
  input logic      out_valid,
  input out_item_t out_data,
  input logic      out_stall
);

  // A stalled digest word holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled digest word changed");

  // Digest words count up in order.
  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !out_data.last_word |=>
      out_valid && out_data.word_index == $past(out_data.word_index) + 3'd1)
    else $error("digest word out of order");

  // Input is held off while digest words go out.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input open during digest output");

  // Last flag marks word seven only.
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.last_word == (out_data.word_index == 3'd7)))
    else $error("last flag mismatch");

endmodule

bind sha256_stream_hasher sha_checker u_chk (
  .clk(clk), .rst(rst), .in_stall(in_stall),
  .out_valid(out_valid), .out_data(out_data), .out_stall(out_stall)
);

>>> sim/sha256_stream_hasher_test.sv
// Testbench for sha256_stream_hasher: streams messages byte by byte and checks
// each digest word against a SHA-256 predictor kept in this file.
// Depends on sha_pkg and the sha256_stream_hasher RTL.
`timescale 1ns / 1ps

module sha256_stream_hasher_test
  import sha_pkg::*;
();

  localparam int CYCLE_LIMIT = 2000000;

  logic      clk;
  logic      rst;
  logic      in_valid;
  in_item_t  in_data;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_data;
  logic      out_stall;

  // Predictor state: chaining words, block buffer, fill count, bit length.
  logic [31:0] hash_state [8];
  logic [7:0]  msg_block [64];
  int          block_fill;
  logic [63:0] msg_bits;

  out_item_t digest_queue [$];
  int        fail_count;
  int        cycle_count;
  int        stall_left;
  bit        stim_done;

  sha256_stream_hasher dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_data(in_data), .in_stall(in_stall),
    .out_valid(out_valid), .out_data(out_data), .out_stall(out_stall)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [31:0] rotr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // One SHA-256 compression of the block buffer into the chaining words.
  task automatic compress_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2;
    for (int i = 0; i < 16; i++) begin
      w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    end
    for (int i = 16; i < 64; i++) begin
      s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = s0 + w[i-16] + s1 + w[i-7];
    end
    for (int i = 0; i < 8; i++) v[i] = hash_state[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] += v[i];
  endtask

  task automatic restart_message();
    for (int i = 0; i < 8; i++) hash_state[i] = INIT_VEC[i];
    block_fill = 0;
    msg_bits = '0;
  endtask

  // Advance the predictor by one accepted word and queue any digest words.
  task automatic predict_word(in_item_t it);
    out_item_t o;
    if (it.has_byte) begin
      msg_block[block_fill] = it.data_byte;
      block_fill++;
      msg_bits += 64'd8;
      if (block_fill == 64) begin
        compress_block();
        block_fill = 0;
      end
    end
    if (it.end_of_message) begin
      msg_block[block_fill] = PAD_BYTE;
      block_fill++;
      if (block_fill > LEN_START) begin
        while (block_fill < 64) msg_block[block_fill++] = 8'h00;
        compress_block();
        block_fill = 0;
      end
      while (block_fill < LEN_START) msg_block[block_fill++] = 8'h00;
      for (int i = 0; i < 8; i++) msg_block[63-i] = msg_bits[8*i +: 8];
      compress_block();
      for (int i = 0; i < 8; i++) begin
        o.digest_word = hash_state[i];
        o.word_index = 3'(i);
        o.last_word = (i == 7);
        digest_queue.push_back(o);
      end
      restart_message();
    end
  endtask

  // Send one word after a random gap; the predictor runs at acceptance.
  // Valid stays high after acceptance so that words can follow back to back.
  task automatic send_word(logic [7:0] b, logic hb, logic eom, bit no_gap = 0);
    int gap;
    in_item_t it;
    gap = no_gap ? 0 : ($urandom_range(0, 3) == 0 ? $urandom_range(0, 12) : 0);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    it.data_byte = b;
    it.has_byte = hb;
    it.end_of_message = eom;
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    predict_word(it);
  endtask

  // Send a message of n random bytes; end flag rides on the last byte or alone.
  task automatic send_message(int n, bit eom_alone);
    for (int i = 0; i < n; i++) begin
      send_word(8'($urandom), 1'b1, (!eom_alone && i == n - 1));
    end
    if (eom_alone || n == 0) send_word(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (digest_queue.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    // Empty message, then a byte of all ones and of all zeros.
    send_word(8'h00, 1'b0, 1'b1);
    send_word(8'hff, 1'b1, 1'b1);
    send_word(8'h00, 1'b0, 1'b0);
    send_word(8'h00, 1'b1, 1'b1);
    // A word with no byte and no end does nothing mid-message.
    send_word(8'h61, 1'b1, 1'b0);
    send_word(8'h5a, 1'b0, 1'b0);
    send_word(8'h62, 1'b1, 1'b0);
    send_word(8'h63, 1'b1, 1'b1);
    wait_drained();
  endtask

  task automatic test_pad_boundaries();
    // Lengths around the point where padding needs a second block.
    send_message(55, 0);
    send_message(56, 1);
    send_message(63, 0);
    send_message(64, 1);
    wait_drained();
  endtask

  task automatic test_random();
    int sent;
    int n;
    sent = 0;
    while (sent < 40) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(56, 70) : $urandom_range(0, 20);
      send_message(n, $urandom_range(0, 1));
      sent += n + 1;
      if ($urandom_range(0, 4) == 0) wait_drained();
    end
  endtask

  // Output side: a random wait before each word, and compare each digest word.
  always @(posedge clk) begin
    out_item_t exp_word;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        stall_left = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : 0;
        if (digest_queue.size() == 0) begin
          $display("%0t: unexpected digest word %h", $time, out_data);
          fail_count++;
        end else begin
          exp_word = digest_queue.pop_front();
          if (out_data.digest_word !== exp_word.digest_word) begin
            $display("%0t: digest_word expected %h actual %h", $time,
                     exp_word.digest_word, out_data.digest_word);
            fail_count++;
          end
          if (out_data.word_index !== exp_word.word_index) begin
            $display("%0t: word_index expected %0d actual %0d", $time,
                     exp_word.word_index, out_data.word_index);
            fail_count++;
          end
          if (out_data.last_word !== exp_word.last_word) begin
            $display("%0t: last_word expected %b actual %b", $time,
                     exp_word.last_word, out_data.last_word);
            fail_count++;
          end
        end
      end
      if (stim_done) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= (stall_left != 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  // Cycle limit guards against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    fail_count = 0;
    cycle_count = 0;
    stim_done = 0;
    for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;
    restart_message();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_pad_boundaries();
    test_random();
    wait_drained();
    stim_done = 1;
    repeat (200) @(posedge clk);
    if (fail_count == 0 && digest_queue.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
